@@ src/ifdf_pkg.sv @@
// Package for the interest flood duplicate filter.
// Holds the beat payload types, the action codes, the table entry layout and the FSM states.
// No dependencies.
package ifdf_pkg;

    typedef struct packed {
        logic [15:0] sink_id;
        logic [7:0]  type_id;
        logic [31:0] seq;
        logic [7:0]  ttl;
        logic [15:0] random_sample;
    } ifdf_in_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] ttl_out;
    } ifdf_out_t;

    typedef struct packed {
        logic [15:0] sink_id;
        logic [7:0]  type_id;
        logic [31:0] seq;
    } ifdf_entry_t;

    localparam logic [1:0] ACT_DROP_TTL  = 2'd0;
    localparam logic [1:0] ACT_DROP_PROB = 2'd1;
    localparam logic [1:0] ACT_DROP_DUP  = 2'd2;
    localparam logic [1:0] ACT_FORWARD   = 2'd3;

    localparam logic [15:0] THRESHOLD_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_RESULT
    } ifdf_state_t;

endpackage

@@ src/ifdf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ifdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/ifdf_ctrl.sv @@
// Sequencer and shared compare unit: walks the table one slot a cycle, then decides and updates.
// Depends on ifdf_pkg; drives one ifdf_ram instance through its port.
module ifdf_ctrl #(
    parameter int TABLE_DEPTH = 16,
    localparam int IW = $clog2(TABLE_DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  ifdf_pkg::ifdf_in_t  in_data,
    input  logic [15:0]         threshold,
    output logic                res_valid,
    input  logic                res_take,
    output ifdf_pkg::ifdf_out_t res_data,
    output logic                rd_en,
    output logic [IW-1:0]       rd_addr,
    input  ifdf_pkg::ifdf_entry_t rd_data,
    output logic                wr_en,
    output logic [IW-1:0]       wr_addr,
    output ifdf_pkg::ifdf_entry_t wr_data
);
    import ifdf_pkg::*;

    localparam logic [IW:0] IDX_END = (IW+1)'(TABLE_DEPTH);
    localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_DEPTH - 1);

    ifdf_state_t state_reg, state_next;
    ifdf_in_t item_reg, item_next;
    logic [7:0] ttl_new_reg, ttl_new_next;
    logic [1:0] action_reg, action_next;
    logic [IW:0] idx_reg, idx_next;
    logic cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0] cmp_idx_reg, cmp_idx_next;
    logic match_found_reg, match_found_next;
    logic [IW-1:0] match_idx_reg, match_idx_next;
    logic [31:0] match_seq_reg, match_seq_next;
    logic free_found_reg, free_found_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [IW-1:0] evict_reg, evict_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;

    logic accept;
    logic [7:0] in_ttl_new;

    assign accept = in_valid && in_ready;
    assign in_ttl_new = (in_data.ttl != 8'd0) ? in_data.ttl - 8'd1 : 8'd0;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_ttl_new == 8'd0 || in_data.random_sample > threshold) begin
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (idx_reg == IDX_END) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: state_next = ST_RESULT;
            ST_RESULT: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        item_next        = item_reg;
        ttl_new_next     = ttl_new_reg;
        action_next      = action_reg;
        idx_next         = idx_reg;
        cmp_vld_next     = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        match_seq_next   = match_seq_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        evict_next       = evict_reg;
        valid_next       = valid_reg;
        in_ready         = 1'b0;
        res_valid        = 1'b0;
        rd_en            = 1'b0;
        rd_addr          = idx_reg[IW-1:0];
        wr_en            = 1'b0;
        wr_addr          = match_idx_reg;
        wr_data          = '{sink_id: item_reg.sink_id, type_id: item_reg.type_id,
                             seq: item_reg.seq};

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (accept) begin
                    item_next        = in_data;
                    ttl_new_next     = in_ttl_new;
                    idx_next         = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    if (in_ttl_new == 8'd0) begin
                        action_next = ACT_DROP_TTL;
                    end else if (in_data.random_sample > threshold) begin
                        action_next = ACT_DROP_PROB;
                    end else begin
                        action_next = ACT_FORWARD;
                    end
                end
            end
            ST_SCAN: begin
                if (idx_reg != IDX_END) begin
                    rd_en        = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = idx_reg[IW-1:0];
                    idx_next     = idx_reg + 1'b1;
                end
                if (cmp_vld_reg) begin
                    if (valid_reg[cmp_idx_reg]) begin
                        if (!match_found_reg && rd_data.sink_id == item_reg.sink_id
                                && rd_data.type_id == item_reg.type_id) begin
                            match_found_next = 1'b1;
                            match_idx_next   = cmp_idx_reg;
                            match_seq_next   = rd_data.seq;
                        end
                    end else if (!free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                    end
                end
            end
            ST_DECIDE: begin
                if (match_found_reg && match_seq_reg >= item_reg.seq) begin
                    action_next = ACT_DROP_DUP;
                end else begin
                    action_next = ACT_FORWARD;
                    wr_en       = 1'b1;
                    if (match_found_reg) begin
                        wr_addr = match_idx_reg;
                    end else if (free_found_reg) begin
                        wr_addr               = free_idx_reg;
                        valid_next[free_idx_reg] = 1'b1;
                    end else begin
                        wr_addr            = evict_reg;
                        valid_next[evict_reg] = 1'b1;
                        evict_next = (evict_reg == IDX_LAST) ? '0 : evict_reg + 1'b1;
                    end
                end
            end
            ST_RESULT: res_valid = 1'b1;
            default: ;
        endcase
    end

    assign res_data = '{action: action_reg, ttl_out: ttl_new_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cmp_vld_reg <= 1'b0;
            evict_reg   <= '0;
            valid_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            evict_reg   <= evict_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg        <= item_next;
        ttl_new_reg     <= ttl_new_next;
        action_reg      <= action_next;
        idx_reg         <= idx_next;
        cmp_idx_reg     <= cmp_idx_next;
        match_found_reg <= match_found_next;
        match_idx_reg   <= match_idx_next;
        match_seq_reg   <= match_seq_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
    end

endmodule

@@ src/interest_flood_duplicate_filter.sv @@
// Interest flood duplicate filter: TTL decrement, probabilistic drop, duplicate suppression.
// Input beat s_data, result beat m_data, one configuration register (forward threshold).
// Handshake: each item is accepted on the s_ channel when s_valid and s_ready are high and
// gives exactly one result beat on the m_ channel (action, ttl_out).
// cfg_wr_en/cfg_wr_data write the Q0.16 forward threshold; write only while idle.
// An item dropped for TTL or by probability goes from acceptance to the result state and
// then into the output register; an item that searches the table first walks every slot,
// reading one RAM slot a cycle through the shared compare unit, then passes the
// decide/update state before the result state. A new item is accepted only once the
// result of the last one has been taken.
// s_ready is high only while the sequencer is idle.
// Reset (aresetn low, synchronous) clears all slot valid bits, the eviction pointer and
// the output valid flag, and sets the threshold to 65535; no clearing pass is needed.
// When the receiver stalls, the result beat holds in the output register; the block
// still accepts and processes the next item, and stalls only when its own result is
// ready and the output register is still full.
module interest_flood_duplicate_filter #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ifdf_pkg::ifdf_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ifdf_pkg::ifdf_out_t m_data,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data
);
    import ifdf_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);

    logic [15:0] threshold_reg;
    logic        m_valid_reg;
    ifdf_out_t   m_data_reg;

    logic        res_valid;
    logic        res_take;
    ifdf_out_t   res_data;
    logic        rd_en;
    logic [IW-1:0] rd_addr;
    logic [$bits(ifdf_entry_t)-1:0] rd_raw;
    ifdf_entry_t rd_data;
    logic        wr_en;
    logic [IW-1:0] wr_addr;
    ifdf_entry_t wr_data;

    assign rd_data  = ifdf_entry_t'(rd_raw);
    assign res_take = res_valid && (!m_valid_reg || m_ready);

    ifdf_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .threshold (threshold_reg),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_data  (res_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    ifdf_ram #(.WIDTH($bits(ifdf_entry_t)), .DEPTH(TABLE_DEPTH)) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                threshold_reg <= cfg_wr_data;
            end
            if (res_take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ src/ifdf_chk.sv @@
// Port-level checker for interest_flood_duplicate_filter, with its bind statement.
// Depends on ifdf_pkg and the top level's port list.
module ifdf_chk (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input ifdf_pkg::ifdf_out_t m_data
);
    import ifdf_pkg::*;

    // stalled result beat holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // ttl_out of zero exactly when the TTL expired
    a_ttl_action: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.action == ACT_DROP_TTL) == (m_data.ttl_out == 8'd0)))
        else $error("action and ttl_out disagree");

    // one item at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready straight after an accepted beat");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind interest_flood_duplicate_filter ifdf_chk u_ifdf_chk (.*);
